>>> rtl/ols_pkg.sv
package ols_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned STAT_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_DELETE    = 3'd2,
        REQ_FIND      = 3'd3,
        REQ_READ      = 3'd4,
        REQ_DUP       = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } stat_t;

endpackage

>>> rtl/ols_req_if.sv
interface ols_req_if
    import ols_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key_in;
    logic [POS_W-1:0]        position_in;

    modport source (
        output valid,
        output req_type,
        output key_in,
        output position_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  key_in,
        input  position_in,
        output ready
    );
endinterface

>>> rtl/ols_rsp_if.sv
interface ols_rsp_if
    import ols_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key_out;
    logic [POS_W-1:0]        position_out;
    logic [POS_W-1:0]        count_out;

    modport source (
        output valid,
        output status,
        output key_out,
        output position_out,
        output count_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  key_out,
        input  position_out,
        input  count_out,
        output ready
    );
endinterface

>>> rtl/ordered_list_store.sv
// inserts and rejected requests skip the walk and go from transfer straight to the result; read fetches one entry
// find: walks from the front, stops at the first match, one stored entry compared per cycle through the memory port
// delete: moves each later entry down one place; duplicate: appends a copy of every entry (one entry copied per cycle)
// one request in work at a time; a new request transfers while the previous result waits
// reset: entry count and head pointer cleared; memory contents are not cleared (no sweep)
module ordered_list_store
    import ols_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ols_req_if.sink    req,
    ols_rsp_if.source  rsp
);

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    state_t            state_reg, state_next;
    req_t              op_reg, op_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     rd_end_reg, rd_end_next;
    logic [AW-1:0]     start_reg, start_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    stat_t             res_status_reg, res_status_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic              out_valid_reg, out_valid_next;
    stat_t             out_status_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_count_reg;

    logic              load_out;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   count_ext;
    logic [CMPW-1:0]   find_pos;
    logic [AW-1:0]     pos_m1;
    logic [AW-1:0]     head_dec;
    logic              is_empty;
    logic              is_full;
    logic              dup_over;
    logic              pos_ok;
    logic              is_last;

    assign pos_ext   = CMPW'(req.position_in);
    assign count_ext = CMPW'(count_reg);
    assign find_pos  = CMPW'(pend_idx_reg) + CMPW'(1);
    assign pos_m1    = AW'(pos_ext - CMPW'(1));
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign dup_over  = (({1'b0, count_reg} + {1'b0, count_reg}) > (CW + 1)'(DEPTH));
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
    assign is_last   = ((CW'(pend_idx_reg) + CW'(1)) == rd_end_reg);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.key_out      = out_key_reg;
    assign rsp.position_out = out_pos_reg;
    assign rsp.count_out    = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_end_next     = rd_end_reg;
        start_next      = start_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        load_out        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = req.key_in;
                    pos_next        = req.position_in;
                    op_next         = req_t'(req.req_type);
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    res_pos_next    = '0;
                    state_next      = S_DONE;
                    case (req_t'(req.req_type))
                        REQ_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                wr_data    = req.key_in;
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg[AW-1:0]);
                                wr_data    = req.key_in;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE, REQ_READ:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                res_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next  = S_WALK;
                                start_next  = pos_m1;
                                rd_idx_next = CW'(pos_m1);
                                rd_end_next = (req_t'(req.req_type) == REQ_READ)
                                              ? CW'(pos_ext) : count_reg;
                            end
                        end
                        REQ_FIND:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next  = S_WALK;
                                start_next  = '0;
                                rd_idx_next = '0;
                                rd_end_next = count_reg;
                            end
                        end
                        REQ_DUP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (dup_over)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next  = S_WALK;
                                start_next  = '0;
                                rd_idx_next = '0;
                                rd_end_next = count_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // read one entry ahead, act on the entry read in the previous cycle
                if (rd_idx_reg < rd_end_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = phys(head_reg, rd_idx_reg[AW-1:0]);
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    case (op_reg)
                        REQ_FIND:
                        begin
                            if (rdata_reg == key_reg)
                            begin
                                res_status_next = ST_OK;
                                res_key_next    = key_reg;
                                res_pos_next    = find_pos[POS_W-1:0];
                                state_next      = S_DONE;
                            end
                            else if (is_last)
                            begin
                                res_status_next = ST_NOTFOUND;
                                state_next      = S_DONE;
                            end
                        end
                        REQ_READ:
                        begin
                            res_key_next = rdata_reg;
                            res_pos_next = pos_reg;
                            state_next   = S_DONE;
                        end
                        REQ_DELETE:
                        begin
                            if (pend_idx_reg == start_reg)
                            begin
                                res_key_next = rdata_reg;
                                res_pos_next = pos_reg;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = phys(head_reg, pend_idx_reg - AW'(1));
                                wr_data = rdata_reg;
                            end
                            if (is_last)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_DONE;
                            end
                        end
                        REQ_DUP:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = phys(head_reg, AW'(CW'(pend_idx_reg) + count_reg));
                            wr_data = rdata_reg;
                            if (is_last)
                            begin
                                count_next = count_reg + count_reg;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                if (state_next != S_WALK)
                begin
                    pend_next = 1'b0;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= REQ_INS_FRONT;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_end_reg    <= '0;
            start_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_end_reg    <= rd_end_next;
            start_reg     <= start_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pos_reg    <= res_pos_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_pos_reg    <= res_pos_reg;
            out_count_reg  <= count_ext[POS_W-1:0];
        end
    end

    // the walk never reads and writes the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write collide on one entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("entry count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_WALK))
    else $error("pending read outside walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (op_reg == REQ_DELETE || op_reg == REQ_READ ||
                                   op_reg == REQ_FIND || op_reg == REQ_DUP))
    else $error("walk started for a request that needs none");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> $stable(count_reg) || (state_reg != S_DONE) ||
                                      $past(state_reg) != S_DONE)
    else $error("entry count changed while result held");

endmodule
